// ===== design/pcc_pkg.sv =====
`default_nettype none
package pcc_pkg;

  localparam int CAL_W     = 16;
  localparam int CAL_IDX_W = 3;

  // configuration register indexes
  localparam logic [CAL_IDX_W-1:0] CFG_PRES_SENS  = 3'd0;
  localparam logic [CAL_IDX_W-1:0] CFG_PRES_OFF   = 3'd1;
  localparam logic [CAL_IDX_W-1:0] CFG_SENS_TC    = 3'd2;
  localparam logic [CAL_IDX_W-1:0] CFG_OFF_TC     = 3'd3;
  localparam logic [CAL_IDX_W-1:0] CFG_TEMP_REF   = 3'd4;
  localparam logic [CAL_IDX_W-1:0] CFG_TEMP_COEFF = 3'd5;

  // queue between front and back
  localparam int MQ_DEPTH = 4;
  localparam int MQ_PTR_W = 2;
  localparam int MQ_CNT_W = 3;

  // result queue; also the credit window of the back pipeline
  localparam int OQ_DEPTH = 16;
  localparam int OQ_PTR_W = 4;
  localparam int OQ_CNT_W = 5;

  localparam int PIPE_DEPTH = 8;

  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } in_item_t;

  typedef struct packed {
    logic signed [14:0] temperature;
    logic [16:0]        pressure;
    logic               clipped;
  } out_item_t;

  typedef struct packed {
    logic [CAL_W-1:0] c1;
    logic [CAL_W-1:0] c2;
    logic [CAL_W-1:0] c3;
    logic [CAL_W-1:0] c4;
    logic [CAL_W-1:0] c5;
    logic [CAL_W-1:0] c6;
  } cal_t;

  // item after the front: raw pressure and difference temperature
  typedef struct packed {
    logic [23:0]        d1;
    logic signed [24:0] dt;
  } work_t;

endpackage
`default_nettype wire

// ===== design/pcc_front.sv =====
`default_nettype none
module pcc_front
  import pcc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire in_item_t   in_item,
  input  wire logic [CAL_W-1:0] ref_temp,
  input  wire logic       deq,
  output logic            q_valid,
  output work_t           q_item
);

  logic [MQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MQ_PTR_W-1:0] wr_r, wr_nxt;
  logic [MQ_PTR_W-1:0] rd_r, rd_nxt;
  work_t               mem_r [MQ_DEPTH];
  work_t               entry;
  logic                do_push;
  logic                do_pop;

  assign full    = (cnt_r == MQ_CNT_W'(MQ_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = deq && q_valid;

  // difference temperature: raw reading minus reference scaled by 256
  always_comb begin
    entry.d1 = in_item.raw_pressure;
    entry.dt = $signed({1'b0, in_item.raw_temperature}) - $signed({1'b0, ref_temp, 8'h00});
  end

  always_comb begin
    wr_nxt  = do_push ? wr_r + MQ_PTR_W'(1) : wr_r;
    rd_nxt  = do_pop  ? rd_r + MQ_PTR_W'(1) : rd_r;
    cnt_nxt = cnt_r;
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + MQ_CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - MQ_CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wr_r  <= '0;
      rd_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= entry;
    end
  end

endmodule
`default_nettype wire

// ===== design/pcc_back.sv =====
`default_nettype none
module pcc_back
  import pcc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cal_t  cal,
  input  wire logic  q_valid,
  input  wire work_t q_item,
  output logic       deq,
  input  wire logic  res_pop,
  output logic       res_valid,
  output out_item_t  res_item
);

  localparam logic signed [19:0] TEMP_BASE = 20'sd2000;
  localparam logic signed [18:0] COLD_OFS  = 19'sd3500;
  localparam logic signed [19:0] TEMP_LO   = -20'sd4000;
  localparam logic signed [19:0] TEMP_HI   = 20'sd8500;
  localparam logic signed [28:0] PRES_HI   = 29'sd131071;

  logic [OQ_CNT_W-1:0]   pending_r, pending_nxt;
  logic [PIPE_DEPTH-1:0] v_r, v_nxt;
  logic                  issue;

  // stage 1: products with dt
  logic signed [41:0] s1_mt_r, s1_mo_r, s1_ms_r;
  logic signed [49:0] s1_sq_r;
  logic [23:0]        s1_d1_r;
  // stage 2: first-order terms
  logic signed [17:0] s2_a_r;
  logic signed [41:0] s2_off_r, s2_sens_r;
  logic [16:0]        s2_t2_r;
  logic [23:0]        s2_d1_r;
  // stage 3: squares for the cold corrections
  logic [34:0]        s3_asq_r;
  logic [35:0]        s3_bsq_r;
  logic               s3_lo_r, s3_vlo_r;
  logic signed [19:0] s3_temp_r;
  logic signed [41:0] s3_off_r, s3_sens_r;
  logic [23:0]        s3_d1_r;
  // stage 4: correction terms, temperature clamp
  logic [40:0]        s4_off2_r;
  logic [39:0]        s4_sens2_r;
  logic signed [14:0] s4_temp_r;
  logic               s4_thit_r;
  logic signed [41:0] s4_off_r, s4_sens_r;
  logic [23:0]        s4_d1_r;
  // stage 5: corrected offset and sensitivity
  logic signed [41:0] s5_off_r, s5_sens_r;
  logic signed [14:0] s5_temp_r;
  logic               s5_thit_r;
  logic [23:0]        s5_d1_r;
  // stage 6: partial products of raw pressure and sensitivity
  logic [43:0]        s6_pl_r;
  logic signed [44:0] s6_ph_r;
  logic signed [41:0] s6_off_r;
  logic signed [14:0] s6_temp_r;
  logic               s6_thit_r;
  // stage 7: full product
  logic signed [63:0] s7_prod_r;
  logic signed [41:0] s7_off_r;
  logic signed [14:0] s7_temp_r;
  logic               s7_thit_r;
  // stage 8: result
  out_item_t          s8_res_r;

  logic signed [16:0] c3s, c4s, c6s;
  logic signed [18:0] b;
  logic signed [35:0] asq_full;
  logic signed [37:0] bsq_full;
  logic [40:0]        off2_61;
  logic [39:0]        bsq_15;
  logic signed [43:0] p1;
  logic signed [28:0] p;
  out_item_t          res_nxt;

  assign issue     = q_valid && (pending_r < OQ_CNT_W'(OQ_DEPTH));
  assign deq       = issue;
  assign res_valid = v_r[PIPE_DEPTH-1];
  assign res_item  = s8_res_r;

  assign c3s = $signed({1'b0, cal.c3});
  assign c4s = $signed({1'b0, cal.c4});
  assign c6s = $signed({1'b0, cal.c6});

  always_comb begin
    v_nxt       = {v_r[PIPE_DEPTH-2:0], issue};
    pending_nxt = pending_r;
    case ({issue, res_pop})
      2'b10:   pending_nxt = pending_r + OQ_CNT_W'(1);
      2'b01:   pending_nxt = pending_r - OQ_CNT_W'(1);
      default: pending_nxt = pending_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      v_r       <= '0;
    end else begin
      pending_r <= pending_nxt;
      v_r       <= v_nxt;
    end
  end

  // stage 3 and 4 helpers
  always_comb begin
    b        = 19'(s2_a_r) + COLD_OFS;
    asq_full = 36'(s2_a_r) * 36'(s2_a_r);
    bsq_full = 38'(b) * 38'(b);
    off2_61  = 41'(s3_asq_r) * 41'(61);
    bsq_15   = 40'(s3_bsq_r) * 40'(15);
  end

  // stage 8: pressure and clamps
  always_comb begin
    p1 = 44'($signed(s7_prod_r[63:21])) - 44'(s7_off_r);
    p  = p1[43:15];
    res_nxt.temperature = s7_temp_r;
    res_nxt.clipped     = s7_thit_r;
    if (p[28]) begin
      res_nxt.pressure = '0;
      res_nxt.clipped  = 1'b1;
    end else if (p > PRES_HI) begin
      res_nxt.pressure = '1;
      res_nxt.clipped  = 1'b1;
    end else begin
      res_nxt.pressure = p[16:0];
    end
  end

  always_ff @(posedge clk) begin
    // stage 1
    s1_mt_r <= 42'(q_item.dt) * 42'(c6s);
    s1_mo_r <= 42'(q_item.dt) * 42'(c4s);
    s1_ms_r <= 42'(q_item.dt) * 42'(c3s);
    s1_sq_r <= 50'(q_item.dt) * 50'(q_item.dt);
    s1_d1_r <= q_item.d1;

    // stage 2: shifted products fit below bit 41, take them by part-select
    s2_a_r    <= $signed(s1_mt_r[40:23]);
    s2_off_r  <= $signed({9'd0, cal.c2, 17'd0}) + 42'($signed(s1_mo_r[40:6]));
    s2_sens_r <= $signed({10'd0, cal.c1, 16'd0}) + 42'($signed(s1_ms_r[40:7]));
    s2_t2_r   <= s1_sq_r[47:31];
    s2_d1_r   <= s1_d1_r;

    // stage 3: a is TEMP-2000, b is TEMP+1500
    s3_asq_r  <= asq_full[34:0];
    s3_bsq_r  <= bsq_full[35:0];
    s3_lo_r   <= s2_a_r[17];
    s3_vlo_r  <= b[18];
    s3_temp_r <= 20'(s2_a_r) + TEMP_BASE
                 - (s2_a_r[17] ? 20'($signed({1'b0, s2_t2_r})) : 20'sd0);
    s3_off_r  <= s2_off_r;
    s3_sens_r <= s2_sens_r;
    s3_d1_r   <= s2_d1_r;

    // stage 4: corrections apply only below 20 C, the extra ones below -15 C
    if (s3_lo_r) begin
      s4_off2_r  <= 41'(off2_61[40:4]) + (s3_vlo_r ? 41'(bsq_15) : 41'd0);
      s4_sens2_r <= 40'({s3_asq_r, 1'b0}) + (s3_vlo_r ? 40'({s3_bsq_r, 3'b000}) : 40'd0);
    end else begin
      s4_off2_r  <= '0;
      s4_sens2_r <= '0;
    end
    if (s3_temp_r < TEMP_LO) begin
      s4_temp_r <= TEMP_LO[14:0];
      s4_thit_r <= 1'b1;
    end else if (s3_temp_r > TEMP_HI) begin
      s4_temp_r <= TEMP_HI[14:0];
      s4_thit_r <= 1'b1;
    end else begin
      s4_temp_r <= s3_temp_r[14:0];
      s4_thit_r <= 1'b0;
    end
    s4_off_r  <= s3_off_r;
    s4_sens_r <= s3_sens_r;
    s4_d1_r   <= s3_d1_r;

    // stage 5
    s5_off_r  <= s4_off_r - $signed({1'b0, s4_off2_r});
    s5_sens_r <= s4_sens_r - $signed({2'b00, s4_sens2_r});
    s5_temp_r <= s4_temp_r;
    s5_thit_r <= s4_thit_r;
    s5_d1_r   <= s4_d1_r;

    // stage 6: split sensitivity into a low unsigned and a high signed half
    s6_pl_r   <= 44'(s5_d1_r) * 44'(s5_sens_r[19:0]);
    s6_ph_r   <= 45'($signed({1'b0, s5_d1_r})) * 45'($signed(s5_sens_r[39:20]));
    s6_off_r  <= s5_off_r;
    s6_temp_r <= s5_temp_r;
    s6_thit_r <= s5_thit_r;

    // stage 7
    s7_prod_r <= (64'(s6_ph_r) <<< 20) + $signed({20'd0, s6_pl_r});
    s7_off_r  <= s6_off_r;
    s7_temp_r <= s6_temp_r;
    s7_thit_r <= s6_thit_r;

    // stage 8
    s8_res_r <= res_nxt;
  end

endmodule
`default_nettype wire

// ===== design/pcc_outq.sv =====
`default_nettype none
module pcc_outq
  import pcc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      res_valid,
  input  wire out_item_t res_item,
  input  wire logic      pop,
  output logic           empty,
  output out_item_t      out_item,
  output logic           pop_ok
);

  logic [OQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [OQ_PTR_W-1:0] wr_r, wr_nxt;
  logic [OQ_PTR_W-1:0] rd_r, rd_nxt;
  out_item_t           mem_r [OQ_DEPTH];

  assign empty    = (cnt_r == '0);
  assign out_item = mem_r[rd_r];
  assign pop_ok   = pop && !empty;

  // no full check: the back pipeline only issues against free entries
  always_comb begin
    wr_nxt  = res_valid ? wr_r + OQ_PTR_W'(1) : wr_r;
    rd_nxt  = pop_ok    ? rd_r + OQ_PTR_W'(1) : rd_r;
    cnt_nxt = cnt_r;
    case ({res_valid, pop_ok})
      2'b10:   cnt_nxt = cnt_r + OQ_CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - OQ_CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wr_r  <= '0;
      rd_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      mem_r[wr_r] <= res_item;
    end
  end

endmodule
`default_nettype wire

// ===== design/pressure_temperature_compensation_core.sv =====
// Second-order barometric compensation. Push a pair of raw 24-bit pressure and
// temperature conversions; pop the temperature in 0.01 C (saturated to -40.00
// .. 85.00) and the pressure in 0.01 mbar (saturated to 0 .. 131071), with
// clipped set when either was saturated. The six calibration words are written
// through the cfg port; the user must do so only while the block is idle, which
// the block itself does not enforce. Writes to indexes above five are dropped.
// One item is taken per clock while full is low: a four-entry input queue feeds
// an eight-stage arithmetic pipeline. At sixteen issued, unpopped results the
// pipeline stops issuing; the input queue then fills and raises full.
`default_nettype none
module pressure_temperature_compensation_core
  import pcc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  output logic                      full,
  input  wire in_item_t             in_item,
  output logic                      empty,
  input  wire logic                 pop,
  output out_item_t                 out_item,
  input  wire logic                 cfg_we,
  input  wire logic [CAL_IDX_W-1:0] cfg_index,
  input  wire logic [CAL_W-1:0]     cfg_wdata
);

  cal_t      cal_r, cal_nxt;
  logic      q_valid;
  work_t     q_item;
  logic      deq;
  logic      res_valid;
  out_item_t res_item;
  logic      pop_ok;

  always_comb begin
    cal_nxt = cal_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_PRES_SENS:  cal_nxt.c1 = cfg_wdata;
        CFG_PRES_OFF:   cal_nxt.c2 = cfg_wdata;
        CFG_SENS_TC:    cal_nxt.c3 = cfg_wdata;
        CFG_OFF_TC:     cal_nxt.c4 = cfg_wdata;
        CFG_TEMP_REF:   cal_nxt.c5 = cfg_wdata;
        CFG_TEMP_COEFF: cal_nxt.c6 = cfg_wdata;
        default:        cal_nxt = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  pcc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .ref_temp (cal_r.c5),
    .deq      (deq),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  pcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cal       (cal_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .deq       (deq),
    .res_pop   (pop_ok),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  pcc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_item  (res_item),
    .pop       (pop),
    .empty     (empty),
    .out_item  (out_item),
    .pop_ok    (pop_ok)
  );

endmodule
`default_nettype wire

// ===== design/pcc_checker.sv =====
`default_nettype none
module pcc_protocol_checker
  import pcc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      push,
  input wire logic      full,
  input wire logic      empty,
  input wire logic      pop,
  input wire out_item_t out_item
);

  localparam logic signed [14:0] T_MIN = -15'sd4000;
  localparam logic signed [14:0] T_MAX = 15'sd8500;

  // items accepted but not yet popped
  logic [5:0] cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push && !full, pop && !empty})
      2'b10:   cnt_nxt = cnt_r + 6'd1;
      2'b01:   cnt_nxt = cnt_r - 6'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not cleared by reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> cnt_r != 6'd0)
    else $error("result shown with no item outstanding");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ($signed(out_item.temperature) >= T_MIN &&
                $signed(out_item.temperature) <= T_MAX))
    else $error("temperature outside saturation range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("waiting result changed or dropped");

endmodule

bind pressure_temperature_compensation_core pcc_protocol_checker u_pcc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);
`default_nettype wire

// ===== bench/pcc_checker.sv =====
`timescale 1ns / 1ps
module pcc_checker
  import pcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic                 full,
  input  in_item_t             in_item,
  input  logic                 empty,
  input  logic                 pop,
  input  out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CAL_IDX_W-1:0] cfg_index,
  input  logic [CAL_W-1:0]     cfg_wdata,
  output int                   mismatches,
  output int                   outstanding
);

  cal_t      cal_words;
  out_item_t awaited_results[$];

  // Second-order compensation over signed 64-bit intermediates.
  function automatic out_item_t compensate(input in_item_t pair, input cal_t cw);
    longint    raw_p, raw_t;
    longint    sens_w, off_w, sens_tc, off_tc, ref_w, temp_tc;
    longint    dtemp, t_cc, offset, sensitivity;
    longint    t_corr, off_corr, sens_corr, cold, frigid, pres;
    out_item_t r;
    raw_p   = pair.raw_pressure;
    raw_t   = pair.raw_temperature;
    sens_w  = cw.c1;
    off_w   = cw.c2;
    sens_tc = cw.c3;
    off_tc  = cw.c4;
    ref_w   = cw.c5;
    temp_tc = cw.c6;
    t_corr    = 0;
    off_corr  = 0;
    sens_corr = 0;

    dtemp       = raw_t - ref_w * 256;
    t_cc        = 2000 + ((dtemp * temp_tc) >>> 23);
    offset      = off_w * 131072 + ((off_tc * dtemp) >>> 6);
    sensitivity = sens_w * 65536 + ((sens_tc * dtemp) >>> 7);

    if (t_cc < 2000) begin
      cold      = t_cc - 2000;
      t_corr    = (dtemp * dtemp) >>> 31;
      off_corr  = (61 * cold * cold) >>> 4;
      sens_corr = 2 * cold * cold;
      if (t_cc < -1500) begin
        frigid    = t_cc + 1500;
        off_corr  = off_corr + 15 * frigid * frigid;
        sens_corr = sens_corr + 8 * frigid * frigid;
      end
    end

    t_cc        = t_cc - t_corr;
    offset      = offset - off_corr;
    sensitivity = sensitivity - sens_corr;
    pres        = (((raw_p * sensitivity) >>> 21) - offset) >>> 15;

    r.clipped = 1'b0;
    if (t_cc < -4000) begin
      t_cc      = -4000;
      r.clipped = 1'b1;
    end else if (t_cc > 8500) begin
      t_cc      = 8500;
      r.clipped = 1'b1;
    end
    if (pres < 0) begin
      pres      = 0;
      r.clipped = 1'b1;
    end else if (pres > 131071) begin
      pres      = 131071;
      r.clipped = 1'b1;
    end
    r.temperature = t_cc[14:0];
    r.pressure    = pres[16:0];
    return r;
  endfunction

  initial begin
    mismatches  = 0;
    outstanding = 0;
    cal_words   = '0;
  end

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      cal_words = '0;
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        // indexes past the last word are dropped
        case (cfg_index)
          CFG_PRES_SENS:  cal_words.c1 = cfg_wdata;
          CFG_PRES_OFF:   cal_words.c2 = cfg_wdata;
          CFG_SENS_TC:    cal_words.c3 = cfg_wdata;
          CFG_OFF_TC:     cal_words.c4 = cfg_wdata;
          CFG_TEMP_REF:   cal_words.c5 = cfg_wdata;
          CFG_TEMP_COEFF: cal_words.c6 = cfg_wdata;
          default: ;
        endcase
      end
      if (push && !full)
        awaited_results.push_back(compensate(in_item, cal_words));
      if (pop && !empty) begin
        if (awaited_results.size() == 0) begin
          $error("out_item: nothing expected, got temperature %0d pressure %0d clipped %0b",
                 out_item.temperature, out_item.pressure, out_item.clipped);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (out_item.temperature !== want.temperature) begin
            $error("temperature: expected %0d, actual %0d",
                   want.temperature, out_item.temperature);
            mismatches++;
          end
          if (out_item.pressure !== want.pressure) begin
            $error("pressure: expected %0d, actual %0d", want.pressure, out_item.pressure);
            mismatches++;
          end
          if (out_item.clipped !== want.clipped) begin
            $error("clipped: expected %0b, actual %0b", want.clipped, out_item.clipped);
            mismatches++;
          end
        end
      end
    end
    outstanding = awaited_results.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import pcc_pkg::*;

  localparam logic [CAL_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CAL_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int    SETTLE_CYCLES = 20;
  localparam int    RAND_PHASES   = 8;
  localparam int    PHASE_ITEMS   = 110;
  localparam int    RAW_MAX       = 16777215;
  localparam cal_t  TYPICAL_CAL   = {16'd40127, 16'd36924, 16'd23317,
                                     16'd23282, 16'd33464, 16'd28312};
  localparam cal_t  ALL_ONES_CAL  = {6{16'hFFFF}};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 push = 1'b0;
  logic                 pop = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CAL_IDX_W-1:0] cfg_index = '0;
  logic [CAL_W-1:0]     cfg_wdata = '0;
  in_item_t             in_item = '0;
  logic                 full, empty;
  out_item_t            out_item;
  int                   mismatches, outstanding;

  cal_t cal_now = '0;   // calibration as last loaded, used to aim raw temperatures
  int   in_streak = 0;
  int   out_streak = 0;

  pressure_temperature_compensation_core uut (
    .clk, .rst_n, .push, .full, .in_item, .empty, .pop, .out_item,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  pcc_checker scoreboard (
    .clk, .rst_n, .push, .full, .in_item, .empty, .pop, .out_item,
    .cfg_we, .cfg_index, .cfg_wdata, .mismatches, .outstanding
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Mostly uniform waits, with occasional back-to-back streaks.
  function automatic int pick_gap(inout int streak);
    if (streak > 0) begin
      streak--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      streak = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // Raw temperature that lands near the wanted first-order temperature.
  function automatic logic [23:0] aim_raw_temp(input int target);
    longint coeff, ref_w, dt, raw;
    coeff = cal_now.c6;
    ref_w = cal_now.c5;
    if (coeff == 0)
      return 24'($urandom_range(0, RAW_MAX));
    dt  = (longint'(target) - 2000) * 8388608 / coeff;
    raw = ref_w * 256 + dt + $urandom_range(0, 255) - 128;
    if (raw < 0)
      raw = 0;
    if (raw > RAW_MAX)
      raw = RAW_MAX;
    return raw[23:0];
  endfunction

  task automatic send_item(input logic [23:0] raw_p, input logic [23:0] raw_t);
    int gap;
    gap = pick_gap(in_streak);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push                    = 1'b1;
    in_item.raw_pressure    = raw_p;
    in_item.raw_temperature = raw_t;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // Drop push, wait until every result is back, then let the pipeline go quiet.
  task automatic settle();
    push = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CAL_IDX_W-1:0] idx, input logic [CAL_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic load_cal(input cal_t cw);
    write_reg(CFG_PRES_SENS, cw.c1);
    write_reg(CFG_PRES_OFF, cw.c2);
    write_reg(CFG_SENS_TC, cw.c3);
    write_reg(CFG_OFF_TC, cw.c4);
    write_reg(CFG_TEMP_REF, cw.c5);
    write_reg(CFG_TEMP_COEFF, cw.c6);
    cal_now = cw;
  endtask

  function automatic logic [15:0] jitter_word(input logic [15:0] base);
    return base ^ 16'($urandom_range(0, 4095));
  endfunction

  function automatic logic [15:0] edge_word();
    case ($urandom_range(0, 2))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Drain side: wait, then hold pop until one item leaves.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = pick_gap(out_streak);
      if (gap > 0) begin
        pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop = 1'b1;
      do @(posedge clk); while (empty);
      @(negedge clk);
    end
  end

  initial begin
    cal_t        cw;
    int          kind;
    logic [23:0] raw_p, raw_t;

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // uncalibrated: all words still zero
    send_item(24'd0, 24'd0);
    send_item(24'hFFFFFF, 24'hFFFFFF);
    send_item(24'hFFFFFF, 24'd0);
    send_item(24'd0, 24'hFFFFFF);
    settle();

    load_cal(TYPICAL_CAL);
    send_item(24'd9085466, 24'd8569150);
    send_item(24'd9085466, {TYPICAL_CAL.c5, 8'd0});          // exactly 20.00 C
    send_item(24'd9085466, {TYPICAL_CAL.c5, 8'd0} - 24'd1);  // just below 20.00 C
    send_item(24'd9085466, aim_raw_temp(1000));
    send_item(24'd9085466, aim_raw_temp(-1500));
    send_item(24'd9085466, aim_raw_temp(-2500));
    send_item(24'd0, 24'd8569150);
    send_item(24'hFFFFFF, 24'd8569150);
    send_item(24'd9085466, 24'd0);
    send_item(24'd9085466, 24'hFFFFFF);
    settle();

    // writes past the last index must leave the calibration alone
    write_reg(CFG_SPARE_LO, 16'hFFFF);
    write_reg(CFG_SPARE_HI, 16'h0000);
    send_item(24'd9085466, 24'd8569150);
    settle();

    load_cal(ALL_ONES_CAL);
    send_item(24'd0, 24'd0);
    send_item(24'hFFFFFF, 24'hFFFFFF);
    send_item(24'hFFFFFF, 24'd0);
    send_item(24'h800000, 24'h7FFFFF);
    settle();

    load_cal({16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF});
    send_item(24'hFFFFFF, 24'hFFFFFF);
    send_item(24'hFFFFFF, aim_raw_temp(-3000));
    settle();

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      kind = $urandom_range(0, 3);
      for (int w = 0; w < 6; w++) begin
        case (kind)
          0:       cw[w*16 +: 16] = 16'($urandom_range(0, 65535));
          1:       cw[w*16 +: 16] = jitter_word(TYPICAL_CAL[w*16 +: 16]);
          2:       cw[w*16 +: 16] = edge_word();
          default: cw[w*16 +: 16] = TYPICAL_CAL[w*16 +: 16];
        endcase
      end
      load_cal(cw);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 9) < 6) begin
          raw_t = aim_raw_temp($urandom_range(0, 16000) - 7000);
          if ($urandom_range(0, 1) == 0)
            raw_p = 24'($urandom_range(6000000, 10000000));
          else
            raw_p = 24'($urandom_range(0, RAW_MAX));
        end else begin
          raw_t = 24'($urandom_range(0, RAW_MAX));
          raw_p = 24'($urandom_range(0, RAW_MAX));
        end
        send_item(raw_p, raw_t);
      end
      settle();
    end

    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
design/pcc_pkg.sv
design/pcc_front.sv
design/pcc_back.sv
design/pcc_outq.sv
design/pressure_temperature_compensation_core.sv
design/pcc_checker.sv
bench/pcc_checker.sv
bench/tb.sv
